@@ sv/ddo_pkg.sv @@
`timescale 1ns / 1ps
package ddo_pkg;

   localparam int CORDIC_STEPS_DEF = 24;
   localparam int FRAC_BITS_DEF    = 16;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_LEFT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_RIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_TRACK    = 2'd2;

   localparam logic [15:0] RADIUS_RST    = 16'd3277;
   localparam logic [23:0] INV_TRACK_RST = 24'd327680;

   localparam logic [31:0] CORDIC_GAIN = 32'd2608131496;
   localparam logic [28:0] INV_4PI     = 29'd341782638;

   localparam int WORK_W    = 60;
   localparam int WORK_FRAC = 24;

   typedef struct packed {
      logic signed [31:0] delta_left;
      logic signed [31:0] delta_right;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic        [31:0] heading;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_L, ST_MUL_R, ST_SUM, ST_MUL_RAD,
      ST_MUL_LO, ST_MUL_HI, ST_GAIN, ST_ROT, ST_UPDATE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_MUL_L, OP_MUL_R, OP_SUM, OP_MUL_RAD,
      OP_MUL_LO, OP_MUL_HI, OP_GAIN, OP_ROT, OP_UPDATE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [4:0]  step;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } sts_type;

   function automatic logic [31:0] atan_bam(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

@@ sv/ddo_ctrl.sv @@
`timescale 1ns / 1ps
module ddo_ctrl #(
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ddo_pkg::sts_type sts,
   output ddo_pkg::cmd_type cmd
);

   localparam int CNT_W = $clog2(CORDIC_STEPS + 1);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

   ddo_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ddo_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd.op    = ddo_pkg::OP_NONE;
      cmd.step  = 5'(step_ff);
      case (state_ff)
         ddo_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = ddo_pkg::OP_LOAD;
               state_in = ddo_pkg::ST_MUL_L;
            end
         end
         ddo_pkg::ST_MUL_L: begin
            cmd.op   = ddo_pkg::OP_MUL_L;
            state_in = ddo_pkg::ST_MUL_R;
         end
         ddo_pkg::ST_MUL_R: begin
            cmd.op   = ddo_pkg::OP_MUL_R;
            state_in = ddo_pkg::ST_SUM;
         end
         ddo_pkg::ST_SUM: begin
            cmd.op   = ddo_pkg::OP_SUM;
            state_in = ddo_pkg::ST_MUL_RAD;
         end
         ddo_pkg::ST_MUL_RAD: begin
            cmd.op   = ddo_pkg::OP_MUL_RAD;
            state_in = ddo_pkg::ST_MUL_LO;
         end
         ddo_pkg::ST_MUL_LO: begin
            cmd.op   = ddo_pkg::OP_MUL_LO;
            state_in = ddo_pkg::ST_MUL_HI;
         end
         ddo_pkg::ST_MUL_HI: begin
            cmd.op   = ddo_pkg::OP_MUL_HI;
            state_in = ddo_pkg::ST_GAIN;
         end
         ddo_pkg::ST_GAIN: begin
            cmd.op   = ddo_pkg::OP_GAIN;
            step_in  = '0;
            state_in = ddo_pkg::ST_ROT;
         end
         ddo_pkg::ST_ROT: begin
            cmd.op = ddo_pkg::OP_ROT;
            if (step_ff == LAST) begin
               state_in = ddo_pkg::ST_UPDATE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ddo_pkg::ST_UPDATE: begin
            if (!sts.out_busy) begin
               cmd.op   = ddo_pkg::OP_UPDATE;
               state_in = ddo_pkg::ST_IDLE;
            end
         end
         default: state_in = ddo_pkg::ST_IDLE;
      endcase
   end

endmodule

@@ sv/ddo_datapath.sv @@
`timescale 1ns / 1ps
module ddo_datapath #(
   parameter int FRAC_BITS = ddo_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ddo_pkg::cmd_type                  cmd,
   output ddo_pkg::sts_type                  sts,
   input  ddo_pkg::req_type                  req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ddo_pkg::rsp_type                  rsp_word,
   input  logic                              csr_valid,
   input  logic [ddo_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ddo_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int W   = ddo_pkg::WORK_W;
   localparam int RSH = (2 * FRAC_BITS >= 32) ? 2 * FRAC_BITS - 32 : 0;
   localparam int LSH = (2 * FRAC_BITS < 32) ? 32 - 2 * FRAC_BITS : 0;
   localparam logic signed [33:0] QTR  = 34'sd1073741824;
   localparam logic signed [33:0] HALF = 34'sd2147483648;
   localparam logic signed [W-1:0] SMAX = W'(64'sd2147483647);
   localparam logic signed [W-1:0] SMIN = W'(-64'sd2147483648);

   logic [15:0] rl_ff, rl_in, rr_ff, rr_in;
   logic [23:0] inv_ff, inv_in;
   logic signed [31:0] dl_ff, dl_in, dr_ff, dr_in;
   logic signed [48:0] sl_ff, sl_in, sr_ff, sr_in;
   logic signed [32:0] travel_ff, travel_in;
   logic signed [33:0] diff_ff, diff_in;
   logic signed [57:0] rad_ff, rad_in;
   logic [31:0] plo_ff, plo_in, half_ff, half_in;
   logic signed [W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic flip_ff, flip_in;
   logic signed [31:0] xacc_ff, xacc_in, yacc_ff, yacc_in;
   logic [31:0] head_ff, head_in;
   logic rsp_valid_ff, rsp_valid_in;
   ddo_pkg::rsp_type rsp_ff, rsp_in;

   logic signed [33:0] ma;
   logic signed [32:0] mb;
   logic signed [66:0] mp;
   logic signed [49:0] sum_w, dif_w;
   logic signed [63:0] rad_ext, rad64;
   logic [31:0] mid;
   logic signed [33:0] z0;
   logic signed [W-1:0] dx, dy, fx, fy, sx, sy;
   logic signed [33:0] at;

   always_ff @(posedge clock) begin
      if (reset) begin
         rl_ff        <= ddo_pkg::RADIUS_RST;
         rr_ff        <= ddo_pkg::RADIUS_RST;
         inv_ff       <= ddo_pkg::INV_TRACK_RST;
         xacc_ff      <= '0;
         yacc_ff      <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rl_ff        <= rl_in;
         rr_ff        <= rr_in;
         inv_ff       <= inv_in;
         xacc_ff      <= xacc_in;
         yacc_ff      <= yacc_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dl_ff     <= dl_in;
      dr_ff     <= dr_in;
      sl_ff     <= sl_in;
      sr_ff     <= sr_in;
      travel_ff <= travel_in;
      diff_ff   <= diff_in;
      rad_ff    <= rad_in;
      plo_ff    <= plo_in;
      half_ff   <= half_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      flip_ff   <= flip_in;
      rsp_ff    <= rsp_in;
   end

   // shared multiplier
   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.op)
         ddo_pkg::OP_MUL_L: begin
            ma = 34'(dl_ff);
            mb = $signed({17'b0, rl_ff});
         end
         ddo_pkg::OP_MUL_R: begin
            ma = 34'(dr_ff);
            mb = $signed({17'b0, rr_ff});
         end
         ddo_pkg::OP_MUL_RAD: begin
            ma = diff_ff;
            mb = $signed({9'b0, inv_ff});
         end
         ddo_pkg::OP_MUL_LO: begin
            ma = $signed({2'b0, rad64[31:0]});
            mb = $signed({4'b0, ddo_pkg::INV_4PI});
         end
         ddo_pkg::OP_MUL_HI: begin
            ma = $signed({2'b0, rad64[63:32]});
            mb = $signed({4'b0, ddo_pkg::INV_4PI});
         end
         ddo_pkg::OP_GAIN: begin
            ma = 34'(travel_ff);
            mb = $signed({1'b0, ddo_pkg::CORDIC_GAIN});
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
      mp = ma * mb;
   end

   always_comb begin
      sum_w   = 50'(sl_ff) + 50'(sr_ff);
      dif_w   = 50'(sl_ff) - 50'(sr_ff);
      rad_ext = 64'(rad_ff);
      rad64   = (rad_ext >>> RSH) << LSH;
      mid     = head_ff + half_ff;
      z0      = 34'($signed(mid));
      dx      = y_ff >>> cmd.step;
      dy      = x_ff >>> cmd.step;
      at      = $signed({2'b0, ddo_pkg::atan_bam(cmd.step)});
      fx      = flip_ff ? -x_ff : x_ff;
      fy      = flip_ff ? -y_ff : y_ff;
      sx      = W'(xacc_ff) + (fx >>> ddo_pkg::WORK_FRAC);
      sy      = W'(yacc_ff) + (fy >>> ddo_pkg::WORK_FRAC);
   end

   always_comb begin
      rl_in        = rl_ff;
      rr_in        = rr_ff;
      inv_in       = inv_ff;
      dl_in        = dl_ff;
      dr_in        = dr_ff;
      sl_in        = sl_ff;
      sr_in        = sr_ff;
      travel_in    = travel_ff;
      diff_in      = diff_ff;
      rad_in       = rad_ff;
      plo_in       = plo_ff;
      half_in      = half_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      flip_in      = flip_ff;
      xacc_in      = xacc_ff;
      yacc_in      = yacc_ff;
      head_in      = head_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_valid) begin
         case (csr_index)
            ddo_pkg::CSR_RADIUS_LEFT:  rl_in  = csr_data[15:0];
            ddo_pkg::CSR_RADIUS_RIGHT: rr_in  = csr_data[15:0];
            ddo_pkg::CSR_INV_TRACK:    inv_in = csr_data;
            default: ;
         endcase
      end

      case (cmd.op)
         ddo_pkg::OP_LOAD: begin
            dl_in = req_word.delta_left;
            dr_in = req_word.delta_right;
         end
         ddo_pkg::OP_MUL_L:   sl_in = mp[48:0];
         ddo_pkg::OP_MUL_R:   sr_in = mp[48:0];
         ddo_pkg::OP_SUM: begin
            travel_in = sum_w[49:17];
            diff_in   = dif_w[49:16];
         end
         ddo_pkg::OP_MUL_RAD: rad_in = mp[57:0];
         ddo_pkg::OP_MUL_LO:  plo_in = mp[63:32];
         ddo_pkg::OP_MUL_HI:  half_in = plo_ff + mp[31:0];
         ddo_pkg::OP_GAIN: begin
            x_in    = W'($signed(mp[66:8]));
            y_in    = '0;
            z_in    = z0;
            flip_in = 1'b0;
            if (z0 > QTR) begin
               z_in    = z0 - HALF;
               flip_in = 1'b1;
            end else if (z0 < -QTR) begin
               z_in    = z0 + HALF;
               flip_in = 1'b1;
            end
         end
         ddo_pkg::OP_ROT: begin
            if (!z_ff[33]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + at;
            end
         end
         ddo_pkg::OP_UPDATE: begin
            if (sx > SMAX) begin
               xacc_in = 32'(SMAX);
            end else if (sx < SMIN) begin
               xacc_in = 32'(SMIN);
            end else begin
               xacc_in = sx[31:0];
            end
            if (sy > SMAX) begin
               yacc_in = 32'(SMAX);
            end else if (sy < SMIN) begin
               yacc_in = 32'(SMIN);
            end else begin
               yacc_in = sy[31:0];
            end
            head_in        = head_ff + {half_ff[30:0], 1'b0};
            rsp_in.pos_x   = xacc_in;
            rsp_in.pos_y   = yacc_in;
            rsp_in.heading = head_in;
            rsp_valid_in   = 1'b1;
         end
         default: ;
      endcase
   end

   assign sts.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word     = rsp_ff;

endmodule

@@ sv/differential_drive_odometry_unit.sv @@
`timescale 1ns / 1ps
// Differential drive odometry.
// req channel: one word per encoder sample, left and right wheel increments.
// rsp channel: one word per request, the updated pose (x, y, heading).
// csr channel: register writes (left radius, right radius, inverse track),
//    always ready; write only while no request is in flight.
// Between request accept and response valid, a request passes the shared
//    multiplier sequence and the one-step-per-cycle CORDIC rotator.
// A new request is taken only after the previous one's pose update.
// The result sits in an output register; if rsp_ready stays low, the
//    next request is still computed but held before the pose update until
//    the output register is taken.
// Reset: pose cleared to zero, registers to their default values.
module differential_drive_odometry_unit #(
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
   parameter int FRAC_BITS    = ddo_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  ddo_pkg::req_type               req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ddo_pkg::rsp_type               rsp_word,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ddo_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ddo_pkg::CSR_DATA_W-1:0] csr_data
);

   ddo_pkg::cmd_type cmd;
   ddo_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   ddo_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ddo_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

@@ sv/ddo_checker.sv @@
`timescale 1ns / 1ps
module ddo_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ddo_pkg::rsp_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("request taken while busy");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !(rsp_valid && !rsp_ready) |=> !$rose(rsp_valid))
      else $error("response before computation");

   a_reset: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("bad state after reset");

endmodule

bind differential_drive_odometry_unit ddo_checker u_ddo_checker (.*);
